[sv/length_prefixed_record_ring_core_assert.svh]
// Assertion macros used by the checker file of the record ring.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LENGTH_PREFIXED_RECORD_RING_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_RECORD_RING_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lprr_pkg.sv]
`default_nettype none

package lprr_pkg;

  localparam int LEN_W  = 13;
  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2,
    ST_ORPHAN = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    op_t               opcode;
    logic [BYTE_W-1:0] put_byte;
    logic              first_of_record;
    logic [LEN_W-1:0]  record_length;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              read_valid;
    logic              record_end;
    status_t           status;
    logic [LEN_W-1:0]  used_bytes;
  } res_t;

endpackage

`default_nettype wire

[sv/lprr_ram.sv]
`default_nettype none

module lprr_ram #(
  parameter int ADDR_W = 12
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic                        re,
  input  wire logic [ADDR_W-1:0]           addr,
  input  wire logic [lprr_pkg::BYTE_W-1:0] wdata,
  output logic      [lprr_pkg::BYTE_W-1:0] rdata
);

  logic [lprr_pkg::BYTE_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[sv/length_prefixed_record_ring_core.sv]
// Put, clear, no-op and empty get: result registered in the cycle after acceptance.
// Non-empty get: the byte passes the registered read of the single-port ring RAM
// and then the result register; no new command is taken until the result is loaded.
// Throughput: one put, clear or no-op per cycle while the result is not stalled.
// Reset (synchronous) clears pointers, counters and the read header state; the
// ring contents are left as they are and need no clearing pass.
`default_nettype none

module length_prefixed_record_ring_core #(
  parameter int BUFFER_BYTES = 4096,
  parameter int HEADER_BYTES = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_stall,
  input  wire lprr_pkg::cmd_t  cmd,
  output logic                 res_valid,
  input  wire logic            res_stall,
  output lprr_pkg::res_t       res
);

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int PTR_W  = ADDR_W + 1;
  localparam int LEN_W  = lprr_pkg::LEN_W;
  localparam int HDR_W  = 8 * HEADER_BYTES;
  localparam int CMP_W  = (PTR_W > LEN_W) ? PTR_W : LEN_W;
  localparam int EFF_W  = (HDR_W > PTR_W) ? HDR_W : PTR_W;

  lprr_pkg::state_t state, state_next;

  logic [PTR_W-1:0] cwp, cwp_next;
  logic [PTR_W-1:0] swp, swp_next;
  logic [PTR_W-1:0] rp, rp_next;
  logic [LEN_W-1:0] put_rem, put_rem_next;
  logic             dropping, dropping_next;
  logic [PTR_W-1:0] rd_count, rd_count_next;
  logic [HDR_W-1:0] hdr_acc, hdr_acc_next;
  logic [PTR_W-1:0] hdr_len, hdr_len_next;
  logic             res_valid_next;
  lprr_pkg::res_t   res_next;
  logic             res_load;

  logic                        ram_we;
  logic                        ram_re;
  logic [ADDR_W-1:0]           ram_addr;
  logic [lprr_pkg::BYTE_W-1:0] ram_rdata;

  logic             accept;
  logic             out_free;
  logic [PTR_W-1:0] used_now;
  logic [PTR_W-1:0] space;
  logic             len_over;
  logic             do_stage;
  logic [PTR_W-1:0] stage_ptr;
  logic [LEN_W-1:0] stage_rem;
  logic [PTR_W-1:0] used_after;

  logic [PTR_W-1:0] rd_count_inc;
  logic [PTR_W-1:0] rp_inc;
  logic [PTR_W-1:0] left;
  logic [HDR_W-1:0] acc_new;
  logic [PTR_W-1:0] cap;
  logic [EFF_W-1:0] eff_lo;
  logic [EFF_W-1:0] eff;
  logic             rec_end;

  assign out_free  = ~res_valid | ~res_stall;
  assign cmd_stall = (state == lprr_pkg::S_READ) | ~out_free;
  assign accept    = cmd_valid & ~cmd_stall;

  assign used_now = cwp - rp;
  assign space    = PTR_W'(BUFFER_BYTES) - used_now;
  assign len_over = CMP_W'(cmd.record_length) > CMP_W'(space);

  // Header decode for the byte coming out of the RAM.
  assign rd_count_inc = rd_count + PTR_W'(1);
  assign rp_inc       = rp + PTR_W'(1);
  assign left         = cwp - rp_inc;
  assign cap          = rd_count_inc + left;

  always_comb begin
    acc_new = (rd_count == '0) ? '0 : hdr_acc;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (rd_count == PTR_W'(i)) begin
        acc_new[8*i +: 8] = ram_rdata;
      end
    end
  end

  assign eff_lo = (EFF_W'(acc_new) < EFF_W'(HEADER_BYTES)) ? EFF_W'(HEADER_BYTES)
                                                            : EFF_W'(acc_new);
  assign eff    = (eff_lo > EFF_W'(cap)) ? EFF_W'(cap) : eff_lo;

  always_comb begin
    if (rd_count_inc < PTR_W'(HEADER_BYTES)) begin
      rec_end = (left == '0);
    end else if (rd_count_inc == PTR_W'(HEADER_BYTES)) begin
      rec_end = eff <= EFF_W'(rd_count_inc);
    end else begin
      rec_end = (rd_count_inc >= hdr_len) || (left == '0);
    end
  end

  always_comb begin
    state_next    = state;
    cwp_next      = cwp;
    swp_next      = swp;
    rp_next       = rp;
    put_rem_next  = put_rem;
    dropping_next = dropping;
    rd_count_next = rd_count;
    hdr_acc_next  = hdr_acc;
    hdr_len_next  = hdr_len;
    res_load      = 1'b0;
    res_next      = res;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = rp[ADDR_W-1:0];
    do_stage      = 1'b0;
    stage_ptr     = swp;
    stage_rem     = put_rem;
    used_after    = used_now;

    unique case (state)
      lprr_pkg::S_IDLE: begin
        if (accept) begin
          res_next.read_byte  = '0;
          res_next.read_valid = 1'b0;
          res_next.record_end = 1'b0;
          res_next.status     = lprr_pkg::ST_OK;
          unique case (cmd.opcode)
            lprr_pkg::OP_PUT: begin
              res_load = 1'b1;
              if (cmd.first_of_record) begin
                swp_next      = cwp;
                put_rem_next  = '0;
                dropping_next = 1'b0;
                if (cmd.record_length == '0) begin
                  res_next.status = lprr_pkg::ST_REJECT;
                end else if (len_over) begin
                  put_rem_next    = cmd.record_length - LEN_W'(1);
                  dropping_next   = cmd.record_length != LEN_W'(1);
                  res_next.status = lprr_pkg::ST_REJECT;
                end else begin
                  do_stage  = 1'b1;
                  stage_ptr = cwp;
                  stage_rem = cmd.record_length;
                end
              end else if (put_rem == '0) begin
                res_next.status = lprr_pkg::ST_ORPHAN;
              end else if (dropping) begin
                put_rem_next    = put_rem - LEN_W'(1);
                dropping_next   = put_rem != LEN_W'(1);
                res_next.status = lprr_pkg::ST_REJECT;
              end else begin
                do_stage = 1'b1;
              end
              if (do_stage) begin
                ram_we       = 1'b1;
                ram_addr     = stage_ptr[ADDR_W-1:0];
                swp_next     = stage_ptr + PTR_W'(1);
                put_rem_next = stage_rem - LEN_W'(1);
                // The last byte of an admitted record publishes the whole record.
                if (stage_rem == LEN_W'(1)) begin
                  cwp_next   = stage_ptr + PTR_W'(1);
                  used_after = stage_ptr + PTR_W'(1) - rp;
                end
              end
            end
            lprr_pkg::OP_GET: begin
              if (used_now == '0) begin
                res_load        = 1'b1;
                res_next.status = lprr_pkg::ST_EMPTY;
                rd_count_next   = '0;
                hdr_acc_next    = '0;
                hdr_len_next    = '0;
              end else begin
                ram_re     = 1'b1;
                state_next = lprr_pkg::S_READ;
              end
            end
            lprr_pkg::OP_CLEAR: begin
              res_load      = 1'b1;
              cwp_next      = '0;
              swp_next      = '0;
              rp_next       = '0;
              put_rem_next  = '0;
              dropping_next = 1'b0;
              rd_count_next = '0;
              hdr_acc_next  = '0;
              hdr_len_next  = '0;
              used_after    = '0;
            end
            lprr_pkg::OP_NOP: begin
              res_load = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
          res_next.used_bytes = LEN_W'(used_after);
        end
      end
      lprr_pkg::S_READ: begin
        if (out_free) begin
          state_next          = lprr_pkg::S_IDLE;
          res_load            = 1'b1;
          rp_next             = rp_inc;
          res_next.read_byte  = ram_rdata;
          res_next.read_valid = 1'b1;
          res_next.record_end = rec_end;
          res_next.status     = lprr_pkg::ST_OK;
          res_next.used_bytes = LEN_W'(left);
          if (rec_end) begin
            rd_count_next = '0;
            hdr_acc_next  = '0;
            hdr_len_next  = '0;
          end else begin
            rd_count_next = rd_count_inc;
            hdr_acc_next  = acc_new;
            if (rd_count_inc == PTR_W'(HEADER_BYTES)) begin
              hdr_len_next = PTR_W'(eff);
            end
          end
        end
      end
      default: begin
        state_next = lprr_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (res_load) begin
      res_valid_next = 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lprr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cwp       <= '0;
      swp       <= '0;
      rp        <= '0;
      put_rem   <= '0;
      dropping  <= 1'b0;
      rd_count  <= '0;
      hdr_acc   <= '0;
      hdr_len   <= '0;
      res_valid <= 1'b0;
    end else begin
      cwp       <= cwp_next;
      swp       <= swp_next;
      rp        <= rp_next;
      put_rem   <= put_rem_next;
      dropping  <= dropping_next;
      rd_count  <= rd_count_next;
      hdr_acc   <= hdr_acc_next;
      hdr_len   <= hdr_len_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  lprr_ram #(
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(cmd.put_byte),
    .rdata(ram_rdata)
  );

endmodule

`default_nettype wire

[sv/lprr_checker.sv]
`default_nettype none

`include "length_prefixed_record_ring_core_assert.svh"

module lprr_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           cmd_valid,
  input wire logic           cmd_stall,
  input wire lprr_pkg::cmd_t cmd,
  input wire logic           res_valid,
  input wire logic           res_stall,
  input wire lprr_pkg::res_t res
);

  `LPRR_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "result changed while stalled")

  `LPRR_ASSERT_NOW(a_no_byte, res_valid && !res.read_valid, res.read_byte == 8'd0 && !res.record_end, "byte or record end without a read")

  `LPRR_ASSERT_NOW(a_empty, res_valid && res.status == lprr_pkg::ST_EMPTY, !res.read_valid && res.used_bytes == '0, "empty get with data or used bytes")

  `LPRR_ASSERT_NEXT(a_clear, cmd_valid && !cmd_stall && cmd.opcode == lprr_pkg::OP_CLEAR, res_valid && res.used_bytes == '0 && res.status == lprr_pkg::ST_OK, "clear did not empty the ring")

endmodule

bind length_prefixed_record_ring_core lprr_checker u_lprr_checker (.*);

`default_nettype wire
